// ===== src/plcp_pkg.sv =====
// Shared widths, constants and types for the peak level centroid pair block.
`default_nettype none
package plcp_pkg;

    localparam int WordW  = 32;
    localparam int CoordW = 11;
    localparam int LevelW = 5;
    localparam int SumW   = 33;
    localparam int CountW = 23;
    localparam int HeightW = 12;
    localparam int CfgIdxW = 1;
    localparam int CfgDataW = HeightW;

    localparam logic [WordW-1:0]   PackedMin   = 32'hFF01_0000;
    localparam logic [WordW-1:0]   PackedSplit = 32'hFF80_0000;
    localparam logic [HeightW-1:0] HeightReset = 12'd480;
    localparam logic [LevelW-1:0]  PeakReset   = 5'd1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ENCODING = 1'b0,
        CFG_HEIGHT   = 1'b1
    } t_cfg_index;

    // Per-class update request.
    typedef struct packed {
        logic              hit;
        logic              clear;
        logic [LevelW-1:0] level;
    } t_acc_ctl;

    // Per-class totals.
    typedef struct packed {
        logic [LevelW-1:0] level;
        logic [SumW-1:0]   sum_x;
        logic [SumW-1:0]   sum_y;
        logic [CountW-1:0] count;
    } t_acc_result;

endpackage
`default_nettype wire

// ===== src/plcp_class_acc.sv =====
// Peak level tracker and centroid sums for one marker class.
`default_nettype none
module plcp_class_acc
    import plcp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_acc_ctl          i_ctl,
    input  wire logic [CoordW-1:0] i_x,
    input  wire logic [CoordW-1:0] i_y,
    output t_acc_result            o_next
);

    t_acc_result r_acc;
    t_acc_result n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.hit) begin
            if (i_ctl.level > r_acc.level) begin
                // A higher level restarts the sums with this pixel alone.
                n_acc.level = i_ctl.level;
                n_acc.sum_x = {{(SumW-CoordW){1'b0}}, i_x};
                n_acc.sum_y = {{(SumW-CoordW){1'b0}}, i_y};
                n_acc.count = {{(CountW-1){1'b0}}, 1'b1};
            end else if (i_ctl.level == r_acc.level) begin
                n_acc.sum_x = r_acc.sum_x + {{(SumW-CoordW){1'b0}}, i_x};
                n_acc.sum_y = r_acc.sum_y + {{(SumW-CoordW){1'b0}}, i_y};
                n_acc.count = r_acc.count + {{(CountW-1){1'b0}}, 1'b1};
            end
        end
    end

    assign o_next = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_acc.level <= PeakReset;
            r_acc.sum_x <= '0;
            r_acc.sum_y <= '0;
            r_acc.count <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule
`default_nettype wire

// ===== src/peak_level_centroid_pair.sv =====
// Top level of the two-class peak level centroid accumulator.
// A word is classified and accumulated as it leaves the input register;
// the frame result is loaded at that same edge, as its last word leaves the input register.
// Throughput: one word per cycle, set by the input register and the
// 33-bit adds per class; only a last word waits while the result register is full.
// Reset is synchronous, active low: peaks return to 1, sums and counts to 0.
`default_nettype none
module peak_level_centroid_pair
    import plcp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [WordW-1:0]    i_pixel_word,
    input  wire logic [CoordW-1:0]   i_pos_x,
    input  wire logic [CoordW-1:0]   i_pos_y,
    input  wire logic                i_frame_last,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [LevelW-1:0]        o_first_level,
    output logic [SumW-1:0]          o_first_sum_x,
    output logic [SumW-1:0]          o_first_sum_y,
    output logic [CountW-1:0]        o_first_count,
    output logic [LevelW-1:0]        o_second_level,
    output logic [SumW-1:0]          o_second_sum_x,
    output logic [SumW-1:0]          o_second_sum_y,
    output logic [CountW-1:0]        o_second_count
);

    logic               r_encoding;
    logic [HeightW-1:0] r_height;

    logic               r_in_valid;
    logic [WordW-1:0]   r_word;
    logic [CoordW-1:0]  r_x;
    logic [CoordW-1:0]  r_y;
    logic               r_last;

    logic               r_out_valid;
    t_acc_result        r_res_one;
    t_acc_result        r_res_two;

    logic               advance;
    logic               in_take;
    logic               pix_hit;
    logic               pix_two;
    logic [LevelW-1:0]  pix_level;
    logic [CoordW-1:0]  pix_y;
    logic [HeightW-1:0] flip_y;
    logic [LevelW-1:0]  lvl_r;
    logic [LevelW-1:0]  lvl_u;
    t_acc_ctl           ctl_one;
    t_acc_ctl           ctl_two;
    t_acc_result        next_one;
    t_acc_result        next_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoding <= 1'b0;
            r_height   <= HeightReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ENCODING: r_encoding <= i_cfg_data[0];
                CFG_HEIGHT:   r_height   <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // A last word may only leave the input register when the result slot frees.
    assign advance    = r_in_valid && (!r_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_word <= i_pixel_word;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_last <= i_frame_last;
        end
    end

    assign lvl_r  = r_word[7:3];
    assign lvl_u  = r_word[15:11];
    assign flip_y = r_height - 12'd1 - {1'b0, r_y};

    always_comb begin
        if (r_encoding) begin
            pix_hit   = (r_word >= PackedMin);
            pix_two   = (r_word >= PackedSplit);
            pix_level = (lvl_r > lvl_u) ? lvl_r : lvl_u;
            pix_y     = flip_y[CoordW-1:0];
        end else begin
            // Both byte halves use bits 6:3 as the level.
            pix_hit   = (r_word[7:0] != 8'd0);
            pix_two   = r_word[7];
            pix_level = {1'b0, r_word[6:3]};
            pix_y     = r_y;
        end
    end

    always_comb begin
        ctl_one.hit   = advance && pix_hit && !pix_two;
        ctl_one.clear = advance && r_last;
        ctl_one.level = pix_level;
        ctl_two.hit   = advance && pix_hit && pix_two;
        ctl_two.clear = advance && r_last;
        ctl_two.level = pix_level;
    end

    plcp_class_acc u_acc_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_one),
        .i_x     (r_x),
        .i_y     (pix_y),
        .o_next  (next_one)
    );

    plcp_class_acc u_acc_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_two),
        .i_x     (r_x),
        .i_y     (pix_y),
        .o_next  (next_two)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_res_one <= next_one;
            r_res_two <= next_two;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_first_level  = r_res_one.level;
    assign o_first_sum_x  = r_res_one.sum_x;
    assign o_first_sum_y  = r_res_one.sum_y;
    assign o_first_count  = r_res_one.count;
    assign o_second_level = r_res_two.level;
    assign o_second_sum_x = r_res_two.sum_x;
    assign o_second_sum_y = r_res_two.sum_y;
    assign o_second_count = r_res_two.count;

endmodule
`default_nettype wire
